// ===== hw/rtl/period_command_line_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the period command line parser
// clocked on clk, switched off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PERIOD_COMMAND_LINE_PARSER_TOP_ASSERT_SVH
`define PERIOD_COMMAND_LINE_PARSER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define PCLP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define PCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pclp_pkg.sv =====
// ----------------------------------------------------------------------------
// pclp_pkg
// types, character codes and reset values of the period command line parser
// ----------------------------------------------------------------------------
package pclp_pkg;

  localparam int BYTE_W    = 8;
  localparam int PERIOD_W  = 16;
  localparam int ACCUM_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 2'd1;

  localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD = 16'd100;
  localparam logic [PERIOD_W-1:0] RST_MAX_PERIOD = 16'd5000;
  localparam logic [PERIOD_W-1:0] RST_PERIOD     = 16'd500;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h70;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_AFTER_P,
    PH_NUM_WS,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD,
    ST_LONG
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [PERIOD_W-1:0]   period;
  } result_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== hw/rtl/period_command_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// period_command_line_parser_top
// Parses "p <value>" command lines from a byte stream and keeps the period
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one received byte per word, in_tdata[7:0]. CR or LF ends a line.
//   out_*  : one word per non-empty line or per over-long line; out_tuser
//            carries the status (ok, bad command, line too long), out_tdata
//            the stored period after that line.
//   cfg_*  : register writes, index 0 min period, index 1 max period; always
//            ready, to be used while no line result is pending.
// Throughput: one byte per clock cycle while the skid word is empty, set by the
//   single parse step that sits between the input register and the result registers.
// Path: an accepted byte is held in the input register; the parse step acts on
//   it there and registers any line result in the output register, or in the skid.
// Stall: a two-word result buffer (output register plus skid) keeps input
//   flowing while out_tready is low; in_tready drops once both are full and a byte waits.
// Reset (rst_n low, synchronous): parser back to line start, period 500,
//   range 100 to 5000, input and result buffers empty.
// ----------------------------------------------------------------------------
`include "period_command_line_parser_top_assert.svh"

module period_command_line_parser_top #(
  parameter int LINE_BUFFER_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pclp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pclp_pkg::PERIOD_W-1:0]  cfg_data,
  // received bytes
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  // line results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [15:0] period_value
  output logic [1:0]                     out_tuser   // [1:0] status
);
  import pclp_pkg::*;

  localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);
  localparam int MUL_W = ACCUM_W + 4;

  // configuration registers
  logic [PERIOD_W-1:0] min_period_r, max_period_r;

  // input register
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;

  // parser state
  phase_t             phase_r, phase_nxt;
  logic [ACCUM_W-1:0] accum_r, accum_nxt;
  logic               neg_r, neg_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ended_r, ended_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;

  // result buffer
  logic    o_valid_r, skid_valid_r;
  result_t o_data_r, skid_data_r;

  logic               proc_en;
  logic               res_valid;
  result_t            res;
  logic [3:0]         digit;
  logic [MUL_W-1:0]   acc_mul;
  logic [ACCUM_W-1:0] acc_sat;
  logic               is_eol;
  logic [ACCUM_W-1:0] fin_value;
  logic               fin_ok;
  logic               drain;

  assign cfg_ready = 1'b1;

  assign proc_en   = in_valid_r && !skid_valid_r;
  assign in_tready = !in_valid_r || proc_en;

  assign digit   = in_byte_r[3:0];
  assign acc_mul = MUL_W'({accum_r, 3'b000}) + MUL_W'({accum_r, 1'b0}) + MUL_W'(digit);
  // saturate once the product leaves the accumulator range
  assign acc_sat = (|acc_mul[MUL_W-1:ACCUM_W]) ? {ACCUM_W{1'b1}} : acc_mul[ACCUM_W-1:0];
  assign is_eol  = (in_byte_r == CH_CR) || (in_byte_r == CH_LF);

  // "p" with only whitespace after it reads as zero
  assign fin_value = (phase_r == PH_NUM_WS) ? '0 : accum_r;
  assign fin_ok    = ((phase_r == PH_NUM_WS) || (phase_r == PH_DIGITS) ||
                      (phase_r == PH_TRAIL))
                   && (!neg_r || (fin_value == '0))
                   && (fin_value >= ACCUM_W'(min_period_r))
                   && (fin_value <= ACCUM_W'(max_period_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= RST_MIN_PERIOD;
      max_period_r <= RST_MAX_PERIOD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_PERIOD: min_period_r <= cfg_data;
        CFG_MAX_PERIOD: max_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (proc_en) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // parse step
  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    neg_nxt    = neg_r;
    len_nxt    = len_r;
    ended_nxt  = ended_r;
    period_nxt = period_r;
    res_valid  = 1'b0;
    res.status = ST_BAD;
    res.period = period_r;
    if (proc_en) begin
      if (is_eol) begin
        if (len_r != '0) begin
          res_valid = 1'b1;
          if (fin_ok) begin
            period_nxt = fin_value[PERIOD_W-1:0];
            res.status = ST_OK;
            res.period = fin_value[PERIOD_W-1:0];
          end
          phase_nxt = PH_LEAD;
          accum_nxt = '0;
          neg_nxt   = 1'b0;
          len_nxt   = '0;
          ended_nxt = 1'b0;
        end
      end else if (len_r < LEN_MAX) begin
        len_nxt = len_r + 1'b1;
        if (!ended_r) begin
          if (in_byte_r == CH_NUL) begin
            ended_nxt = 1'b1;
          end else begin
            case (phase_r)
              PH_LEAD: begin
                if (in_byte_r == CH_P) begin
                  phase_nxt = PH_AFTER_P;
                end else if (!is_blank(in_byte_r)) begin
                  phase_nxt = PH_BAD;
                end
              end
              PH_AFTER_P: begin
                phase_nxt = is_blank(in_byte_r) ? PH_NUM_WS : PH_BAD;
              end
              PH_NUM_WS: begin
                if ((in_byte_r == CH_PLUS) || (in_byte_r == CH_MINUS)) begin
                  neg_nxt   = (in_byte_r == CH_MINUS);
                  phase_nxt = PH_SIGN;
                end else if (is_digit(in_byte_r)) begin
                  accum_nxt = ACCUM_W'(digit);
                  phase_nxt = PH_DIGITS;
                end else if (!is_blank(in_byte_r)) begin
                  phase_nxt = PH_BAD;
                end
              end
              PH_SIGN: begin
                if (is_digit(in_byte_r)) begin
                  accum_nxt = ACCUM_W'(digit);
                  phase_nxt = PH_DIGITS;
                end else begin
                  phase_nxt = PH_BAD;
                end
              end
              PH_DIGITS: begin
                if (is_digit(in_byte_r)) begin
                  accum_nxt = acc_sat;
                end else if (is_blank(in_byte_r)) begin
                  phase_nxt = PH_TRAIL;
                end else begin
                  phase_nxt = PH_BAD;
                end
              end
              PH_TRAIL: begin
                if (!is_blank(in_byte_r)) begin
                  phase_nxt = PH_BAD;
                end
              end
              default: phase_nxt = PH_BAD;
            endcase
          end
        end
      end else begin
        // over-long line: drop the byte and start afresh
        res_valid  = 1'b1;
        res.status = ST_LONG;
        phase_nxt  = PH_LEAD;
        accum_nxt  = '0;
        neg_nxt    = 1'b0;
        len_nxt    = '0;
        ended_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      accum_r  <= '0;
      neg_r    <= 1'b0;
      len_r    <= '0;
      ended_r  <= 1'b0;
      period_r <= RST_PERIOD;
    end else begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      neg_r    <= neg_nxt;
      len_r    <= len_nxt;
      ended_r  <= ended_nxt;
      period_r <= period_nxt;
    end
  end

  // result buffer, output register is the head, skid the second word
  assign drain = o_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r    <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (drain) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!o_valid_r || drain) begin
      o_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (drain) begin
        o_data_r <= skid_data_r;
      end
    end else if (!o_valid_r || drain) begin
      if (res_valid) begin
        o_data_r <= res;
      end
    end else if (res_valid) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r.period;
  assign out_tuser  = o_data_r.status;

  `PCLP_ASSERT_ALWAYS(a_skid_behind_head, !skid_valid_r || o_valid_r,
                      "skid word held with an empty output register")
  `PCLP_ASSERT_ALWAYS(a_len_in_range, len_r <= LEN_MAX,
                      "line length beyond the buffer size")
  `PCLP_ASSERT_NEXT(a_input_held, in_valid_r && !proc_en,
                    in_valid_r && $stable(in_byte_r),
                    "stalled input byte lost or changed")

endmodule

// ===== dv/period_command_line_parser_checker.sv =====
// ----------------------------------------------------------------------------
// period_command_line_parser_checker
// Follows the register, byte and result channels of the parser, works out
// the answer each line should give and compares it with every result word
// ----------------------------------------------------------------------------
module period_command_line_parser_checker #(
  parameter int LINE_BUFFER_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pclp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pclp_pkg::PERIOD_W-1:0]  cfg_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [15:0]                    out_tdata,
  input  logic [1:0]                     out_tuser,
  output int unsigned                    fail_count,
  output int unsigned                    pending
);
  import pclp_pkg::*;

  localparam logic [ACCUM_W-1:0] ACCUM_MAX = '1;

  typedef struct {
    status_t             status;
    logic [PERIOD_W-1:0] period;
  } line_answer_t;

  line_answer_t        answer_q[$];
  logic [PERIOD_W-1:0] min_p;
  logic [PERIOD_W-1:0] max_p;
  logic [PERIOD_W-1:0] period_q;
  phase_t              phase;
  logic [ACCUM_W-1:0]  accum;
  logic                neg;
  logic                text_done;
  int unsigned         line_len;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_line();
    phase     = PH_LEAD;
    accum     = '0;
    neg       = 1'b0;
    line_len  = 0;
    text_done = 1'b0;
  endtask

  // one received byte: either moves the parse on or closes the line
  task automatic predict_answer(input logic [7:0] c);
    status_t            st;
    logic [ACCUM_W-1:0] val;
    int unsigned        grown;
    if (c == CH_CR || c == CH_LF) begin
      if (line_len == 0) return;
      // "p" and blanks with no digits read as zero
      val = (phase == PH_NUM_WS) ? '0 : accum;
      if ((phase == PH_NUM_WS || phase == PH_DIGITS || phase == PH_TRAIL) &&
          (!neg || val == 0) && val >= min_p && val <= max_p) begin
        period_q = val[PERIOD_W-1:0];
        st = ST_OK;
      end else begin
        st = ST_BAD;
      end
      clear_line();
    end else if (line_len + 1 < LINE_BUFFER_BYTES) begin
      line_len++;
      if (text_done) return;
      if (c == CH_NUL) begin
        text_done = 1'b1;
        return;
      end
      case (phase)
        PH_LEAD: begin
          if (c == CH_P) phase = PH_AFTER_P;
          else if (!blank_char(c)) phase = PH_BAD;
        end
        PH_AFTER_P: begin
          phase = blank_char(c) ? PH_NUM_WS : PH_BAD;
        end
        PH_NUM_WS: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            neg   = (c == CH_MINUS);
            phase = PH_SIGN;
          end else if (numeral(c)) begin
            accum = ACCUM_W'(c - CH_ZERO);
            phase = PH_DIGITS;
          end else if (!blank_char(c)) begin
            phase = PH_BAD;
          end
        end
        PH_SIGN: begin
          if (numeral(c)) begin
            accum = ACCUM_W'(c - CH_ZERO);
            phase = PH_DIGITS;
          end else begin
            phase = PH_BAD;
          end
        end
        PH_DIGITS: begin
          if (numeral(c)) begin
            grown = accum * 10 + (c - CH_ZERO);
            accum = (grown > ACCUM_MAX) ? ACCUM_MAX : grown[ACCUM_W-1:0];
          end else if (blank_char(c)) begin
            phase = PH_TRAIL;
          end else begin
            phase = PH_BAD;
          end
        end
        PH_TRAIL: begin
          if (!blank_char(c)) phase = PH_BAD;
        end
        default: begin
          phase = PH_BAD;
        end
      endcase
      return;
    end else begin
      // over-long line: byte dropped, line thrown away
      clear_line();
      st = ST_LONG;
    end
    answer_q.push_back('{status: st, period: period_q});
  endtask

  always @(posedge clk) begin
    line_answer_t want;
    if (!rst_n) begin
      min_p    = RST_MIN_PERIOD;
      max_p    = RST_MAX_PERIOD;
      period_q = RST_PERIOD;
      clear_line();
      answer_q.delete();
    end else begin
      // a result word can never stem from the byte taken at the same edge
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          report($sformatf("result word with nothing expected: status %0d period %0d",
                           out_tuser, out_tdata));
        end else begin
          want = answer_q.pop_front();
          if (out_tuser !== want.status)
            report($sformatf("status %0d, expected %0d", out_tuser, want.status));
          if (out_tdata !== want.period)
            report($sformatf("period %0d, expected %0d", out_tdata, want.period));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_PERIOD: min_p = cfg_data;
          CFG_MAX_PERIOD: max_p = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_answer(in_tdata);
    end
    pending = answer_q.size();
  end

endmodule

// ===== dv/tb_period_command_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// tb_period_command_line_parser_top
// Feeds the parser hand-written command lines and then random ones, well
// formed, broken, over-long and noise, under several period ranges, while
// both sides of the byte stream stall at random; the checker judges results
// ----------------------------------------------------------------------------
module tb_period_command_line_parser_top;
  import pclp_pkg::*;

  localparam int LINE_BYTES  = 64;
  localparam int CYCLE_LIMIT = 500000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [PERIOD_W-1:0]  cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic [1:0]           out_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent   = 0;
  logic        hold_off = 1'b0;
  logic        hold_go  = 1'b0;
  logic        no_gaps  = 1'b0;

  logic [PERIOD_W-1:0] lo_lim = RST_MIN_PERIOD;
  logic [PERIOD_W-1:0] hi_lim = RST_MAX_PERIOD;
  logic [7:0]          text_q[$];
  logic [7:0]          cmd_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  period_command_line_parser_top #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  period_command_line_parser_checker #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: ready in runs, mostly short gaps, now and then a long one
  initial begin : receiver
    int unsigned run;
    int unsigned gap;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      repeat (run) begin
        out_tready <= !hold_off;
        @(posedge clk);
      end
      repeat (gap) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // long hold-off on the result side so that the parser backs up
  initial begin : long_hold
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
          ($urandom_range(0, 2) == 0)  ? $urandom_range(1, 3) : 0;
    if (no_gaps) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text();
    logic [7:0] b;
    no_gaps = ($urandom_range(0, 3) == 0);
    while (text_q.size() != 0) begin
      b = text_q.pop_front();
      send_byte(b);
    end
  endtask

  // wait until every answer is in and the pipe has emptied
  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_range(input logic [PERIOD_W-1:0] lo, input logic [PERIOD_W-1:0] hi);
    drain();
    write_reg(CFG_MIN_PERIOD, lo);
    write_reg(CFG_MAX_PERIOD, hi);
    cfg_valid <= 1'b0;
    lo_lim = lo;
    hi_lim = hi;
  endtask

  function automatic void put_byte(input logic [7:0] b);
    text_q.push_back(b);
  endfunction

  function automatic void put_cmd(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    text_q.push_back(term);
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  // well-formed command with random spacing, sign and digits, no line end
  function automatic void build_cmd();
    int unsigned v;
    int unsigned pick;
    string       ds;
    cmd_q.delete();
    repeat ($urandom_range(0, 3)) cmd_q.push_back(any_blank());
    cmd_q.push_back(CH_P);
    repeat ($urandom_range(1, 3)) cmd_q.push_back(any_blank());
    case ($urandom_range(0, 9))
      0: v = 32'(lo_lim);
      1: v = 32'(hi_lim);
      2: v = 32'(lo_lim) - 1;
      3: v = 32'(hi_lim) + 1;
      4: v = $urandom_range(0, 65535);
      5: v = $urandom_range(0, 99999999);
      default: v = (lo_lim <= hi_lim) ? $urandom_range(lo_lim, hi_lim) : $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 14) != 0) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) cmd_q.push_back(CH_PLUS);
      else if (pick == 1) cmd_q.push_back(CH_MINUS);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) cmd_q.push_back(CH_ZERO);
      ds = $sformatf("%0d", v);
      for (int i = 0; i < ds.len(); i++) cmd_q.push_back(ds[i]);
    end
    repeat ($urandom_range(0, 2)) cmd_q.push_back(any_blank());
  endfunction

  function automatic void random_line();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    build_cmd();
    if (pick < 58) begin
      // left as built
    end else if (pick < 72) begin
      cmd_q[$urandom_range(0, cmd_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 80) begin
      cmd_q.insert($urandom_range(0, cmd_q.size()), CH_NUL);
    end else if (pick < 86) begin
      cmd_q.delete();
      repeat ($urandom_range(1, 12)) cmd_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      // padding around the line length limit
      repeat ($urandom_range(50, 66)) cmd_q.push_front(any_blank());
    end else if (pick < 96) begin
      cmd_q.delete();
    end else begin
      repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    foreach (cmd_q[i]) text_q.push_back(cmd_q[i]);
    text_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    if ($urandom_range(0, 7) == 0) text_q.push_back(CH_LF);
  endfunction

  initial begin : stimulus
    int unsigned phase_end;
    int unsigned a;
    int unsigned b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // range limits under the reset setting, empty lines, all blank kinds
    put_cmd("p 500", CH_LF);
    put_cmd("p 100", CH_CR);
    put_cmd("p 5000", CH_LF);
    put_cmd("p 99", CH_LF);
    put_cmd("p 5001", CH_CR);
    put_byte(CH_LF);
    put_cmd("p 100", CH_CR);
    put_byte(CH_LF);
    put_byte(CH_SPACE);
    put_byte(CH_TAB);
    put_byte(CH_P);
    put_byte(CH_VT);
    put_byte(CH_FF);
    put_byte(CH_TAB);
    put_cmd("+0250 ", CH_FF);
    put_byte(CH_LF);
    // missing parts, signs without digits, saturation
    put_cmd("p", CH_LF);
    put_cmd("p ", CH_CR);
    put_cmd("p -", CH_LF);
    put_cmd("p -7", CH_LF);
    put_cmd("p 12345678901", CH_LF);
    // nul ends the text, the rest of the line is ignored
    put_cmd("p 300", CH_NUL);
    put_cmd("zz", 8'hFF);
    put_byte(CH_LF);
    put_byte(CH_NUL);
    put_byte(CH_LF);
    put_cmd("q 200", CH_LF);
    put_cmd("p 200 x", CH_LF);
    put_cmd("pp 200", CH_LF);
    put_cmd("p 2-00", CH_LF);
    put_cmd("p 200", 8'h80);
    put_byte(CH_LF);
    // longest line that fits, then one byte more
    repeat (57) put_byte(CH_SPACE);
    put_cmd("p 1000", CH_LF);
    repeat (58) put_byte(CH_SPACE);
    put_cmd("p 1000", CH_LF);
    repeat (130) put_byte(8'h78);
    put_byte(CH_LF);
    send_text();

    set_range('0, '0);
    put_cmd("p 0", CH_LF);
    put_cmd("p -0", CH_CR);
    put_cmd("p ", CH_LF);
    put_cmd("p -00", CH_LF);
    put_cmd("p 1", CH_LF);
    send_text();

    set_range('1, '1);
    put_cmd("p 65535", CH_LF);
    put_cmd("p 65536", CH_LF);
    put_cmd("p 131071", CH_LF);
    put_cmd("p 0", CH_LF);
    send_text();

    // crossed range takes nothing
    set_range(16'd5000, 16'd100);
    put_cmd("p 1000", CH_LF);
    put_cmd("p 100", CH_LF);
    send_text();

    set_range('0, '1);
    put_cmd("p -1", CH_LF);
    put_cmd("p 65535", CH_LF);
    send_text();

    hold_go = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        case ($urandom_range(0, 5))
          0: set_range(RST_MIN_PERIOD, RST_MAX_PERIOD);
          1: set_range('0, '1);
          2: begin
            a = $urandom_range(0, 65535);
            b = $urandom_range(0, 65535);
            if (a > b) set_range(PERIOD_W'(b), PERIOD_W'(a));
            else set_range(PERIOD_W'(a), PERIOD_W'(b));
          end
          3: begin
            a = $urandom_range(0, 3000);
            set_range(PERIOD_W'(a), PERIOD_W'(a + $urandom_range(0, 20)));
          end
          4: begin
            a = $urandom_range(1, 65535);
            set_range(PERIOD_W'(a), PERIOD_W'($urandom_range(0, a - 1)));
          end
          default: set_range(PERIOD_W'($urandom_range(0, 200)),
                             PERIOD_W'($urandom_range(1000, 65535)));
        endcase
      end
      phase_end = sent + 130;
      while (sent < phase_end) begin
        random_line();
        send_text();
      end
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== period_command_line_parser_top.f =====
+incdir+hw/rtl
hw/rtl/pclp_pkg.sv
hw/rtl/period_command_line_parser_top.sv
dv/period_command_line_parser_checker.sv
dv/tb_period_command_line_parser_top.sv
